>>> rtl/rbc_pkg.sv
// Shared constants and types for the rank-by-count block.
package rbc_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int OUT_W     = 8;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK  = 2'd0;
    localparam status_t ST_DUP = 2'd1;
    localparam status_t ST_OVF = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_KEY,
        S_CMP,
        S_CHECK,
        S_ERD,
        S_EMIT,
        S_ERR
    } state_t;

endpackage

>>> rtl/rank_by_count_with_duplicate_check_core.sv
// Top level of the rank-by-count block with duplicate check.
//
// Input channel (s_axis): one signed 32-bit value per word in tdata, tlast
// marks the final value of a list and starts the ranking run. Values past
// the store capacity (64) are dropped and the run ends in an overflow word.
// Output channel (m_axis): one word per rank, emitted newest value first;
// tdata[5:0] is the rank (count of list values strictly smaller),
// tdata[7:6] the status (ok, duplicate, overflow); tlast marks the final
// word of a run. A duplicate or an overflow yields a single word with rank 0.
// Loading accepts words back to back while s_axis_tready is high. A run
// over N values uses the single compare unit: each value is fetched, then
// compared against all N stored values, one memory read per compare; each
// result is read from the rank memory before it enters the output register.
// s_axis_tready is low from the final word until the last result is registered.
// Reset clears the list, the overflow flag and the seen-bitmap; the value
// and rank memories need no clearing. When the receiver stalls, the output
// register holds its word and emission waits; loading of a new list may
// start while the last result of the previous run still waits.
module rank_by_count_with_duplicate_check_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rbc_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic                        s_axis_tlast,  // last_value
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rbc_pkg::OUT_W-1:0]   m_axis_tdata,  // [5:0] rank, [7:6] status
    output logic                        m_axis_tlast   // last_result
);
    import rbc_pkg::*;

    // Sequencer state
    state_t state_reg, state_next;

    // List bookkeeping
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   i_reg, i_next;     // value being ranked
    logic [CNT_W-1:0]   j_reg, j_next;     // compare sweep position
    logic [RANK_W-1:0]  cnt_reg, cnt_next; // running count of smaller values
    logic [CNT_W-1:0]   k_reg, k_next;     // ranks stored so far
    logic [IDX_W-1:0]   e_reg, e_next;     // emission index
    logic [MAX_ITEMS-1:0] seen_reg, seen_next;
    status_t            err_reg, err_next;

    // Memories and their registered read data
    logic [VALUE_W-1:0] value_mem [MAX_ITEMS];
    logic [RANK_W-1:0]  rank_mem  [MAX_ITEMS];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [RANK_W-1:0]  rank_rd_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               value_wr;
    logic               rank_wr;

    // Output register
    logic               out_valid_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    status_t            out_status_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               out_load;
    logic [RANK_W-1:0]  out_rank_next;
    status_t            out_status_next;
    logic               out_last_next;

    // Shared compare unit and derived conditions
    logic               key_gt;
    logic               in_accept;
    logic               store_full;
    logic               rank_bad;
    logic               emit_last;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));
    assign key_gt     = (key_reg > rd_data_reg);
    assign rank_bad   = ({1'b0, cnt_reg} >= (RANK_W + 1)'(MAX_ITEMS))
                        || seen_reg[cnt_reg[IDX_W-1:0]];
    assign emit_last  = ((CNT_W'(e_reg) + CNT_W'(1)) == k_reg);
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_status_reg, out_rank_reg};
    assign m_axis_tlast  = out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_accept && s_axis_tlast)
                begin
                    if (ovf_reg || store_full)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: state_next = S_KEY;
            S_KEY:   state_next = S_CMP;
            S_CMP:
            begin
                if (j_reg == count_reg)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (rank_bad)
                begin
                    state_next = S_ERR;
                end
                else if (i_reg == '0)
                begin
                    state_next = S_ERD;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_ERD:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? S_LOAD : S_ERD;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // Datapath control and next values
    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        e_next          = e_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        rd_addr         = i_reg;
        value_wr        = 1'b0;
        rank_wr         = 1'b0;
        out_load        = 1'b0;
        out_rank_next   = '0;
        out_status_next = ST_OK;
        out_last_next   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        value_wr   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    // Rank newest first: the word just taken sits at count_reg
                    i_next   = count_reg[IDX_W-1:0];
                    k_next   = '0;
                    err_next = ST_OVF;
                end
            end
            S_FETCH:
            begin
                rd_addr = i_reg;
            end
            S_KEY:
            begin
                rd_addr  = '0;
                j_next   = CNT_W'(1);
                cnt_next = '0;
            end
            S_CMP:
            begin
                rd_addr  = j_reg[IDX_W-1:0];
                cnt_next = cnt_reg + RANK_W'(key_gt);
                j_next   = j_reg + CNT_W'(1);
            end
            S_CHECK:
            begin
                if (rank_bad)
                begin
                    err_next = ST_DUP;
                end
                else
                begin
                    seen_next[cnt_reg[IDX_W-1:0]] = 1'b1;
                    rank_wr = 1'b1;
                    k_next  = k_reg + CNT_W'(1);
                    i_next  = i_reg - IDX_W'(1);
                    e_next  = '0;
                end
            end
            S_ERD:
            begin
                rd_addr = i_reg;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_rank_next   = rank_rd_reg;
                    out_status_next = ST_OK;
                    out_last_next   = emit_last;
                    e_next          = e_reg + IDX_W'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        seen_next  = '0;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_rank_next   = '0;
                    out_status_next = err_reg;
                    out_last_next   = 1'b1;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    seen_next       = '0;
                end
            end
            default:
            begin
                rd_addr = i_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            seen_reg  <= seen_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        cnt_reg <= cnt_next;
        k_reg   <= k_next;
        e_reg   <= e_next;
        err_reg <= err_next;
        if (state_reg == S_KEY)
        begin
            key_reg <= rd_data_reg;
        end
        if (out_load)
        begin
            out_rank_reg   <= out_rank_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Value memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (value_wr)
        begin
            value_mem[count_reg[IDX_W-1:0]] <= s_axis_tdata;
        end
        rd_data_reg <= value_mem[rd_addr];
    end

    // Rank memory: written in ranking order, read back in the same order
    always_ff @(posedge clk)
    begin
        if (rank_wr)
        begin
            rank_mem[k_reg[IDX_W-1:0]] <= cnt_reg;
        end
        rank_rd_reg <= rank_mem[e_reg];
    end

endmodule

>>> rtl/rbc_checker.sv
// Port-level checker for the rank-by-count block, bound to the top level.
module rbc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [rbc_pkg::VALUE_W-1:0] s_axis_tdata,
    input logic                        s_axis_tlast,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [rbc_pkg::OUT_W-1:0]   m_axis_tdata,
    input logic                        m_axis_tlast
);
    import rbc_pkg::*;

    logic    in_end;
    status_t out_status;

    assign in_end     = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_status = m_axis_tdata[OUT_W-1:RANK_W];

    // A stalled result word holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // An error word closes its run and carries rank zero
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_status != ST_OK |->
            m_axis_tlast && m_axis_tdata[RANK_W-1:0] == '0)
        else $error("error word not final or with nonzero rank");

    // Status never takes the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            out_status == ST_OK || out_status == ST_DUP || out_status == ST_OVF)
        else $error("unused status code on output");

    // The input side is closed in the cycle after a list ends
    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_end |=> !s_axis_tready)
        else $error("input reopened too early after final word");

endmodule

bind rank_by_count_with_duplicate_check_core rbc_checker u_rbc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
